// File: hw/rtl/grid_diffusion_store_top_macros.svh
// Assertion macros for the grid diffusion store.
`ifndef GRID_DIFFUSION_STORE_TOP_MACROS_SVH
`define GRID_DIFFUSION_STORE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GDS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define GDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GDS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

// File: hw/rtl/gds_pkg.sv
// Shared types and constants of the grid diffusion store.
package gds_pkg;
    localparam int DEF_DIM_X      = 16;
    localparam int DEF_DIM_Y      = 16;
    localparam int DEF_DIM_Z      = 16;
    localparam int DEF_LEVEL_BITS = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_W     = 5;
    localparam int RATE_W     = 16;
    localparam int VAL_W      = 32;
    localparam int TOT_W      = 44;
    localparam int POS_W      = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
    localparam logic [RATE_W-1:0] RATE_RESET = 16'd9830;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X    = 2'd0,
        CFG_SIZE_Y    = 2'd1,
        CFG_SIZE_Z    = 2'd2,
        CFG_DIFF_RATE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        REQ_LOAD     = 3'd0,
        REQ_ADD_NUT  = 3'd1,
        REQ_ADD_ACE  = 3'd2,
        REQ_CONSUME  = 3'd3,
        REQ_READ     = 3'd4,
        REQ_DIFFUSE  = 3'd5,
        REQ_UNUSED_A = 3'd6,
        REQ_UNUSED_B = 3'd7
    } req_t;
endpackage

// File: hw/rtl/gds_if.sv
// Request and response channel interfaces of the grid diffusion store.
interface gds_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [2:0]                            req_type;
    logic signed [gds_pkg::POS_W-1:0]      pos_x;
    logic signed [gds_pkg::POS_W-1:0]      pos_y;
    logic signed [gds_pkg::POS_W-1:0]      pos_z;
    logic signed [gds_pkg::VAL_W-1:0]      nutrient_value;
    logic signed [gds_pkg::VAL_W-1:0]      acetate_value;

    modport source (output valid, req_type, pos_x, pos_y, pos_z, nutrient_value,
                    acetate_value, input ready);
    modport sink   (input valid, req_type, pos_x, pos_y, pos_z, nutrient_value,
                    acetate_value, output ready);
endinterface

interface gds_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  in_bounds;
    logic signed [gds_pkg::VAL_W-1:0]      nutrient_out;
    logic signed [gds_pkg::VAL_W-1:0]      acetate_out;
    logic signed [gds_pkg::TOT_W-1:0]      total_nutrient;
    logic signed [gds_pkg::TOT_W-1:0]      total_acetate;

    modport source (output valid, in_bounds, nutrient_out, acetate_out, total_nutrient,
                    total_acetate, input ready);
    modport sink   (input valid, in_bounds, nutrient_out, acetate_out, total_nutrient,
                    total_acetate, output ready);
endinterface

// File: hw/rtl/gds_div.sv
// Bit-serial signed divider by a small count, quotient truncated toward zero.
module gds_div #(
    parameter int W = 35
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic [2:0]          divisor,
    output logic                done,
    output logic signed [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [3:0]    rem_reg;
    logic [2:0]    dvs_reg;
    logic          neg_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [3:0]    rem_sh;

    assign rem_sh   = {rem_reg[2:0], quo_reg[W-1]};
    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // take the magnitude, restore the sign at the end
                quo_reg  <= dividend[W-1] ? 0 - dividend : dividend;
                neg_reg  <= dividend[W-1];
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= {1'b0, dvs_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, dvs_reg};
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// File: hw/rtl/grid_diffusion_store_top.sv
// Top level of the grid diffusion store: sequencer, grid memory and result register.
// Cell requests: accept in idle, read, operate, then put into the result register once it is free.
// A diffuse walks all DIM_X*DIM_Y*DIM_Z cells through one read port, reading each cell and its six
// neighbors in turn; cells outside the active region or without neighbors skip the serial divide.
// After reset a clearing pass over all DIM_X*DIM_Y*DIM_Z cells zeroes bank 0; no word is taken
// during it. Configuration writes take effect at once; make them while no word is in flight.
`include "grid_diffusion_store_top_macros.svh"
module grid_diffusion_store_top #(
    parameter int DIM_X      = gds_pkg::DEF_DIM_X,
    parameter int DIM_Y      = gds_pkg::DEF_DIM_Y,
    parameter int DIM_Z      = gds_pkg::DEF_DIM_Z,
    parameter int LEVEL_BITS = gds_pkg::DEF_LEVEL_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gds_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [gds_pkg::CFG_DATA_W-1:0] cfg_data,
    gds_req_if.sink                        req,
    gds_rsp_if.source                      rsp
);
    localparam int LB    = LEVEL_BITS;
    localparam int CELLS = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (DIM_X > 1) ? $clog2(DIM_X) : 1;
    localparam int YW    = (DIM_Y > 1) ? $clog2(DIM_Y) : 1;
    localparam int ZW    = (DIM_Z > 1) ? $clog2(DIM_Z) : 1;
    localparam int EW    = 10;                    // extent and coordinate compare width
    localparam int SW    = LB + 3;                // sum of up to six levels
    localparam int OW    = ((LB > 32) ? LB : 32) + 3;
    localparam int PW    = LB + 18;               // (LB+1) x 17 product
    localparam int MW    = 2 * LB;
    localparam int VW    = gds_pkg::VAL_W;
    localparam logic [AW-1:0] STEP_Y = AW'(DIM_X);
    localparam logic [AW-1:0] STEP_Z = AW'(DIM_X * DIM_Y);
    localparam logic [AW-1:0] LAST   = AW'(CELLS - 1);
    localparam logic signed [OW-1:0] LMAX = {{(OW-LB+1){1'b0}}, {(LB-1){1'b1}}};
    localparam logic signed [OW-1:0] LMIN = ~LMAX;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CELL_RD, ST_CELL_OP, ST_PUT,
        ST_SW_READ, ST_SW_ACC, ST_SW_DIV, ST_SW_WAIT, ST_SW_MUL, ST_SW_UPD, ST_SW_WR
    } state_t;

    function automatic logic signed [LB-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] c;
        begin
            c = (v > LMAX) ? LMAX : ((v < LMIN) ? LMIN : v);
            sat = c[LB-1:0];
        end
    endfunction

    // configuration registers
    logic [gds_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [gds_pkg::RATE_W-1:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= gds_pkg::SIZE_RESET;
            size_y_reg <= gds_pkg::SIZE_RESET;
            size_z_reg <= gds_pkg::SIZE_RESET;
            rate_reg   <= gds_pkg::RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (gds_pkg::cfg_idx_t'(cfg_idx))
                gds_pkg::CFG_SIZE_X:    size_x_reg <= cfg_data[gds_pkg::SIZE_W-1:0];
                gds_pkg::CFG_SIZE_Y:    size_y_reg <= cfg_data[gds_pkg::SIZE_W-1:0];
                gds_pkg::CFG_SIZE_Z:    size_z_reg <= cfg_data[gds_pkg::SIZE_W-1:0];
                gds_pkg::CFG_DIFF_RATE: rate_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    // active extents, clipped to the lattice
    logic signed [EW-1:0] ext_x, ext_y, ext_z;
    assign ext_x = (EW'(size_x_reg) > EW'(DIM_X)) ? EW'(DIM_X) : EW'(size_x_reg);
    assign ext_y = (EW'(size_y_reg) > EW'(DIM_Y)) ? EW'(DIM_Y) : EW'(size_y_reg);
    assign ext_z = (EW'(size_z_reg) > EW'(DIM_Z)) ? EW'(DIM_Z) : EW'(size_z_reg);

    // sequencer registers
    state_t                state_reg;
    logic                  bank_reg;
    logic [AW-1:0]         addr_reg;
    logic [XW-1:0]         cx_reg;
    logic [YW-1:0]         cy_reg;
    logic [ZW-1:0]         cz_reg;
    logic [2:0]            slot_reg;
    logic [2:0]            cnt_reg;
    logic                  fld_reg;
    logic                  ok_reg;
    gds_pkg::req_t         op_reg;
    logic signed [VW-1:0]  nv_reg, av_reg;
    logic signed [LB-1:0]  old_n_reg, old_a_reg, new_n_reg, new_a_reg;
    logic signed [SW-1:0]  sum_n_reg, sum_a_reg;
    logic signed [LB-1:0]  avg_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [gds_pkg::TOT_W-1:0] tot_n_reg, tot_a_reg;

    // staged word, built while the result register may still hold the previous one
    logic                  sb_reg;
    logic [VW-1:0]         sn_reg, sa_reg;
    logic [gds_pkg::TOT_W-1:0] stn_reg, sta_reg;

    // result register
    logic                  rv_reg;
    logic                  rb_reg;
    logic [VW-1:0]         rn_reg, ra_reg;
    logic [gds_pkg::TOT_W-1:0] rtn_reg, rta_reg;

    // memory: {acetate, nutrient} per word, two banks
    logic [MW-1:0] mem [2**(AW+1)];
    logic [MW-1:0] rdata_reg;
    logic [AW:0]   raddr;
    logic          we;
    logic [AW:0]   waddr;
    logic [MW-1:0] wdata;
    logic signed [LB-1:0] rd_n, rd_a;

    assign rd_n = rdata_reg[LB-1:0];
    assign rd_a = rdata_reg[MW-1:LB];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // request decode
    logic signed [EW-1:0] px, py, pz;
    logic                 req_ok;
    logic [AW-1:0]        req_addr;
    assign px = EW'(req.pos_x);
    assign py = EW'(req.pos_y);
    assign pz = EW'(req.pos_z);
    assign req_ok = (px >= 0) && (px < ext_x) && (py >= 0) && (py < ext_y) &&
                    (pz >= 0) && (pz < ext_z);
    assign req_addr = AW'(int'(px) + DIM_X * (int'(py) + DIM_Y * int'(pz)));

    // sweep neighbor validity, slot 1..6 = +x -x +y -y +z -z
    logic signed [EW-1:0] sx, sy, sz;
    logic                 active;
    logic [6:0]           nvalid;
    assign sx = EW'({1'b0, cx_reg});
    assign sy = EW'({1'b0, cy_reg});
    assign sz = EW'({1'b0, cz_reg});
    assign active = (sx < ext_x) && (sy < ext_y) && (sz < ext_z);
    assign nvalid[0] = 1'b0;
    assign nvalid[1] = active && (sx + 1 < ext_x);
    assign nvalid[2] = active && (sx > 0);
    assign nvalid[3] = active && (sy + 1 < ext_y);
    assign nvalid[4] = active && (sy > 0);
    assign nvalid[5] = active && (sz + 1 < ext_z);
    assign nvalid[6] = active && (sz > 0);

    logic [AW-1:0] slot_addr;
    always_comb
    begin
        unique case (slot_reg)
            3'd1:    slot_addr = addr_reg + AW'(1);
            3'd2:    slot_addr = addr_reg - AW'(1);
            3'd3:    slot_addr = addr_reg + STEP_Y;
            3'd4:    slot_addr = addr_reg - STEP_Y;
            3'd5:    slot_addr = addr_reg + STEP_Z;
            3'd6:    slot_addr = addr_reg - STEP_Z;
            default: slot_addr = addr_reg;
        endcase
    end

    // cell operation
    logic signed [OW-1:0] lvl_n, lvl_a, in_n, in_a, used;
    logic signed [LB-1:0] op_n, op_a;
    assign lvl_n = OW'(rd_n);
    assign lvl_a = OW'(rd_a);
    assign in_n  = OW'(nv_reg);
    assign in_a  = OW'(av_reg);
    assign used  = (lvl_n >= in_n) ? in_n : lvl_n;

    always_comb
    begin
        op_n = rd_n;
        op_a = rd_a;
        unique case (op_reg)
            gds_pkg::REQ_LOAD:    begin op_n = sat(in_n); op_a = sat(in_a); end
            gds_pkg::REQ_ADD_NUT: op_n = sat(lvl_n + in_n);
            gds_pkg::REQ_ADD_ACE: op_a = sat(lvl_a + in_a);
            gds_pkg::REQ_CONSUME: op_n = sat(lvl_n - used);
            default:              ;
        endcase
    end

    // shared divider
    logic                 div_start, div_done;
    logic signed [SW-1:0] div_q;
    assign div_start = (state_reg == ST_SW_DIV) && active && (cnt_reg != 3'd0);

    gds_div #(.W(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (fld_reg ? sum_a_reg : sum_n_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [LB-1:0] old_f;
    logic signed [LB:0]   diff;
    logic signed [LB+1:0] step;
    logic signed [LB-1:0] relaxed;
    assign old_f   = fld_reg ? old_a_reg : old_n_reg;
    assign diff    = (LB+1)'(avg_reg) - (LB+1)'(old_f);
    assign step    = (LB+2)'(prod_reg >>> 16);
    assign relaxed = sat(OW'(old_f) + OW'(step));

    logic signed [63:0] ext_nn, ext_na;
    assign ext_nn = 64'(new_n_reg);
    assign ext_na = 64'(new_a_reg);

    // memory port control
    always_comb
    begin
        we    = 1'b0;
        waddr = {bank_reg, addr_reg};
        wdata = {op_a, op_n};
        raddr = {bank_reg, addr_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = {1'b0, addr_reg};
                wdata = '0;
            end
            ST_CELL_OP: we = ok_reg && (op_reg <= gds_pkg::REQ_CONSUME);
            ST_SW_READ: raddr = {bank_reg, slot_addr};
            ST_SW_WR:
            begin
                we    = 1'b1;
                waddr = {~bank_reg, addr_reg};
                wdata = {new_a_reg, new_n_reg};
            end
            default: ;
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE);

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            bank_reg  <= 1'b0;
            addr_reg  <= '0;
            rv_reg    <= 1'b0;
            slot_reg  <= '0;
            cnt_reg   <= '0;
            fld_reg   <= 1'b0;
        end
        else
        begin
            if (rv_reg && rsp.ready)
                rv_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == LAST)
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg   <= gds_pkg::req_t'(req.req_type);
                        nv_reg   <= req.nutrient_value;
                        av_reg   <= req.acetate_value;
                        ok_reg   <= req_ok;
                        addr_reg <= req_ok ? req_addr : '0;
                        if (gds_pkg::req_t'(req.req_type) == gds_pkg::REQ_DIFFUSE)
                        begin
                            addr_reg  <= '0;
                            cx_reg    <= '0;
                            cy_reg    <= '0;
                            cz_reg    <= '0;
                            slot_reg  <= '0;
                            tot_n_reg <= '0;
                            tot_a_reg <= '0;
                            state_reg <= ST_SW_READ;
                        end
                        else
                            state_reg <= ST_CELL_RD;
                    end
                end
                ST_CELL_RD: state_reg <= ST_CELL_OP;
                ST_CELL_OP:
                begin
                    // build the response word in the stage
                    sb_reg  <= ok_reg && (op_reg <= gds_pkg::REQ_READ);
                    sn_reg  <= '0;
                    sa_reg  <= '0;
                    stn_reg <= '0;
                    sta_reg <= '0;
                    if (ok_reg && op_reg == gds_pkg::REQ_CONSUME)
                        sn_reg <= used[VW-1:0];
                    if (ok_reg && op_reg == gds_pkg::REQ_READ)
                    begin
                        sn_reg <= lvl_n[VW-1:0];
                        sa_reg <= lvl_a[VW-1:0];
                    end
                    state_reg <= ST_PUT;
                end
                ST_PUT:
                begin
                    // hold until the result register is free
                    if (!rv_reg || rsp.ready)
                    begin
                        rv_reg    <= 1'b1;
                        rb_reg    <= sb_reg;
                        rn_reg    <= sn_reg;
                        ra_reg    <= sa_reg;
                        rtn_reg   <= stn_reg;
                        rta_reg   <= sta_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SW_READ:
                begin
                    if (slot_reg == 3'd0)
                    begin
                        sum_n_reg <= '0;
                        sum_a_reg <= '0;
                        cnt_reg   <= '0;
                        fld_reg   <= 1'b0;
                    end
                    state_reg <= ST_SW_ACC;
                end
                ST_SW_ACC:
                begin
                    if (slot_reg == 3'd0)
                    begin
                        old_n_reg <= rd_n;
                        old_a_reg <= rd_a;
                        new_n_reg <= rd_n;
                        new_a_reg <= rd_a;
                    end
                    else if (nvalid[slot_reg])
                    begin
                        sum_n_reg <= sum_n_reg + SW'(rd_n);
                        sum_a_reg <= sum_a_reg + SW'(rd_a);
                        cnt_reg   <= cnt_reg + 3'd1;
                    end
                    if (slot_reg == 3'd6)
                    begin
                        slot_reg  <= '0;
                        state_reg <= ST_SW_DIV;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 3'd1;
                        state_reg <= ST_SW_READ;
                    end
                end
                ST_SW_DIV:
                begin
                    // inactive or isolated cells keep their value
                    if (div_start)
                        state_reg <= ST_SW_WAIT;
                    else
                        state_reg <= ST_SW_WR;
                end
                ST_SW_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_q[LB-1:0];
                        state_reg <= ST_SW_MUL;
                    end
                end
                ST_SW_MUL:
                begin
                    prod_reg  <= PW'(diff) * PW'($signed({1'b0, rate_reg}));
                    state_reg <= ST_SW_UPD;
                end
                ST_SW_UPD:
                begin
                    if (fld_reg)
                    begin
                        new_a_reg <= relaxed;
                        state_reg <= ST_SW_WR;
                    end
                    else
                    begin
                        new_n_reg <= relaxed;
                        fld_reg   <= 1'b1;
                        state_reg <= ST_SW_DIV;
                    end
                end
                ST_SW_WR:
                begin
                    if (active)
                    begin
                        tot_n_reg <= tot_n_reg + ext_nn[gds_pkg::TOT_W-1:0];
                        tot_a_reg <= tot_a_reg + ext_na[gds_pkg::TOT_W-1:0];
                    end
                    // advance x fastest
                    addr_reg <= addr_reg + AW'(1);
                    if (cx_reg == XW'(DIM_X - 1))
                    begin
                        cx_reg <= '0;
                        if (cy_reg == YW'(DIM_Y - 1))
                        begin
                            cy_reg <= '0;
                            cz_reg <= cz_reg + ZW'(1);
                        end
                        else
                            cy_reg <= cy_reg + YW'(1);
                    end
                    else
                        cx_reg <= cx_reg + XW'(1);
                    if (addr_reg == LAST)
                    begin
                        bank_reg  <= ~bank_reg;
                        sb_reg    <= 1'b0;
                        sn_reg    <= '0;
                        sa_reg    <= '0;
                        stn_reg   <= active ? tot_n_reg + ext_nn[gds_pkg::TOT_W-1:0]
                                            : tot_n_reg;
                        sta_reg   <= active ? tot_a_reg + ext_na[gds_pkg::TOT_W-1:0]
                                            : tot_a_reg;
                        state_reg <= ST_PUT;
                    end
                    else
                        state_reg <= ST_SW_READ;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign rsp.valid          = rv_reg;
    assign rsp.in_bounds      = rb_reg;
    assign rsp.nutrient_out   = rn_reg;
    assign rsp.acetate_out    = ra_reg;
    assign rsp.total_nutrient = rtn_reg;
    assign rsp.total_acetate  = rta_reg;

    `GDS_ASSERT_IMPL(a_clear_blocks, clk, rst_n, state_reg == ST_CLEAR, !req.ready, "accept during clear")
    `GDS_ASSERT_IMPL(a_cell_no_total, clk, rst_n, rv_reg && rb_reg, rtn_reg == '0 && rta_reg == '0, "cell word with totals")
    `GDS_ASSERT_ALWAYS(a_nbr_count, clk, rst_n, cnt_reg <= 3'd6, "neighbor count above six")
    `GDS_ASSERT_IMPL(a_div_in_wait, clk, rst_n, div_done, state_reg == ST_SW_WAIT, "divider done outside wait")
endmodule
